// File: sv/rce_pkg.sv
// Shared types and constants for the RBF center energy regressor.
package rce_pkg;

	// Command and result kinds
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RHO_MIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THETA_WINDOW = 2'd3;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] RST_INV_WIDTH    = 16'd6554;
	localparam logic [6:0]  RST_CENTER_COUNT = 7'd64;
	localparam logic [13:0] RST_RHO_MIN      = 14'd9472;
	localparam logic [12:0] RST_THETA_WINDOW = 13'd4669;

	// Event cuts
	localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [15:0] AZ_LIMIT    = 16'd57344;
	localparam logic [15:0] TH_LIMIT    = 16'd32768;

	// Feature normalization: offset, scale and divisor
	localparam logic signed [16:0] LXE_OFS = 17'sd6944;
	localparam logic signed [16:0] CSI_OFS = 17'sd4072;
	localparam logic signed [21:0] RAD_OFS = 22'sd1022976;
	localparam logic [20:0] RAD_MUL = 21'd100;
	localparam logic signed [25:0] A_MUL = 26'sd160;
	localparam logic signed [25:0] B_MUL = 26'sd512;
	localparam logic signed [25:0] C_MUL = 26'sd16;
	localparam logic [8:0] A_DIV = 9'd93;
	localparam logic [8:0] B_DIV = 9'd305;
	localparam logic [8:0] C_DIV = 9'd285;
	localparam int FEAT_QBITS = 18;

	// Reciprocals ceil(2^34 / divisor), exact for numerators below 2^25
	localparam int FNUM_W    = 25;
	localparam int RCP_W     = 28;
	localparam int RCP_SHIFT = 34;
	localparam logic [RCP_W-1:0] A_RCP = 28'd184729777;
	localparam logic [RCP_W-1:0] B_RCP = 28'd56327440;
	localparam logic [RCP_W-1:0] C_RCP = 28'd60280243;

	// Kernel table recursion, Q0.32 ratio
	localparam logic [31:0] EXP_RATIO = 32'd4228380000;
	localparam int KW  = 17;     // kernel value, up to 65536
	localparam int D2W = 34;     // squared distance
	localparam int WKW = 49;     // weight times kernel

	// Divider and output scaling
	localparam int QW = 33;
	localparam int NB_W = 6;
	localparam logic [NB_W-1:0] FINAL_QBITS = 6'd33;
	localparam logic signed [44:0] E_SCALE  = 45'sd800;
	localparam logic signed [44:0] E_OFFSET = 45'sd786464768;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_FILL, ST_IDLE, ST_FSTART, ST_FWAIT, ST_RUN,
		ST_DRAIN, ST_QSTART, ST_QWAIT, ST_SCALE, ST_DONE
	} state_t;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         slot;
		logic signed [15:0] center_a;
		logic signed [15:0] center_b;
		logic signed [15:0] center_c;
		logic signed [31:0] center_weight;
		logic [15:0]        lxe_energy;
		logic [15:0]        csi_energy;
		logic [13:0]        radius;
		logic [15:0]        theta;
		logic [15:0]        azimuth;
		logic [15:0]        bgo_energy;
	} in_t;

	typedef struct packed {
		logic        item_kind;
		logic        accepted;
		logic [15:0] energy;
		logic        no_response;
	} out_t;

	// Control bits that travel down the cell chain
	typedef struct packed {
		logic vld;
		logic last;
	} ctl_t;

	// Data that travels down the cell chain; ctr[0] is consumed by each cell
	typedef struct packed {
		logic [D2W-1:0]   psum;
		logic [31:0]      weight;
		logic [2:0][15:0] ctr;
	} beat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: sv/rce_ram.sv
// Generic single write port RAM with registered read.
module rce_ram #(
	parameter int W  = 32,
	parameter int D  = 64,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/rce_cell.sv
// Distance cell: adds one squared feature difference and passes the beat on.
module rce_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  feat,
	input  rce_pkg::ctl_t       ctl_in,
	input  rce_pkg::beat_t      beat_in,
	output rce_pkg::ctl_t       ctl_out,
	output rce_pkg::beat_t      beat_out
);
	import rce_pkg::*;

	logic signed [16:0] diff;
	logic signed [33:0] sq;
	ctl_t  ctl_q;
	beat_t beat_q;

	// square of this cell's coordinate difference
	assign diff = 17'(feat) - 17'($signed(beat_in.ctr[0]));
	assign sq   = 34'(diff) * 34'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// shift the next coordinate to the front for the neighbor
	always_ff @(posedge clk) begin
		beat_q.psum   <= beat_in.psum + D2W'(unsigned'(sq));
		beat_q.weight <= beat_in.weight;
		beat_q.ctr    <= {16'h0000, beat_in.ctr[2], beat_in.ctr[1]};
	end

	assign ctl_out  = ctl_q;
	assign beat_out = beat_q;
endmodule

// File: sv/rce_div.sv
// Restoring divider, one quotient bit per cycle.
module rce_div #(
	parameter int DDW = 56,
	parameter int RW  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DDW-1:0]               dividend,
	input  logic [RW-1:0]                divisor,
	input  logic [rce_pkg::NB_W-1:0]     nbits,
	output rce_pkg::div_stat_t           stat,
	output logic [rce_pkg::QW-1:0]       quo
);
	import rce_pkg::*;

	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   den_q;
	logic [DDW-1:0]  num_q;
	logic [QW-1:0]   quo_q;
	logic [NB_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW:0]     cat;
	logic [RW:0]     diff;
	logic            ge;

	// trial subtract with the next dividend bit
	assign cat  = {rem_q, num_q[DDW-1]};
	assign diff = cat - {1'b0, den_q};
	assign ge   = cat >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high bits above the quotient range seed the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dividend >> nbits);
			num_q <= dividend << (DDW - 32'(nbits));
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? RW'(diff) : RW'(cat);
			num_q <= num_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;
endmodule

// File: sv/rbf_center_energy_regressor_unit.sv
// Top level of the RBF center energy regressor: control, stores, cell chain.
//
// A load item writes one center and weight and answers in the cycle after it
// is taken; a rejected event answers likewise. A passing event keeps the block
// busy through three feature scalings by reciprocal multiplication, one center
// per cycle into the three-cell distance chain, a drain through kernel index,
// table read and weight product, a quotient on the serial divider, and the
// scaling and result states. With no centers it goes from the scalings straight
// to the result, and when the kernel sum is zero it skips the divider. The done
// strobe is registered from the result state and rises in the cycle in which
// busy drops. After reset the kernel table is built in its RAM, one entry per
// cycle, and the block stays busy until it is complete. The done strobe is high
// for one cycle and the result cannot be held off; configuration writes are
// taken in any cycle.
module rbf_center_energy_regressor_unit #(
	parameter int MAX_CENTERS     = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  rce_pkg::in_t                     item,
	output logic                             done,
	output rce_pkg::out_t                    result,
	input  logic                             wr_en,
	input  logic [rce_pkg::CFG_IDX_W-1:0]    wr_idx,
	input  logic [rce_pkg::CFG_DATA_W-1:0]   wr_data
);
	import rce_pkg::*;

	localparam int AW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CNW = $clog2(MAX_CENTERS + 1);
	localparam int TW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
	localparam int SKW = KW + CNW;
	localparam int NW  = WKW + CNW;
	localparam int FPW = FNUM_W + RCP_W;

	// configuration registers
	logic [15:0] inv_width_q;
	logic [6:0]  center_count_q;
	logic [13:0] rho_min_q;
	logic [12:0] theta_window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_width_q    <= RST_INV_WIDTH;
			center_count_q <= RST_CENTER_COUNT;
			rho_min_q      <= RST_RHO_MIN;
			theta_window_q <= RST_THETA_WINDOW;
		end else if (wr_en) begin
			unique case (wr_idx)
				CFG_INV_WIDTH:    inv_width_q    <= wr_data;
				CFG_CENTER_COUNT: center_count_q <= wr_data[6:0];
				CFG_RHO_MIN:      rho_min_q      <= wr_data[13:0];
				CFG_THETA_WINDOW: theta_window_q <= wr_data[12:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic acc, is_load, is_eval, rejected, load_hit;
	logic div_start, issue, fill_we;
	logic [15:0] dth;

	// beat acceptance and event cuts
	assign acc     = start && !busy;
	assign is_load = acc && (item.cmd == CMD_LOAD);
	assign is_eval = acc && (item.cmd == CMD_EVAL);
	assign load_hit = is_load && (11'(item.slot) < 11'(MAX_CENTERS));
	assign dth = (item.theta >= HALF_PI_Q13) ? item.theta - HALF_PI_Q13
		: HALF_PI_Q13 - item.theta;
	assign rejected = (item.azimuth > AZ_LIMIT) || (item.theta > TH_LIMIT) ||
		(item.radius < rho_min_q) || (dth > {3'b000, theta_window_q}) ||
		(item.bgo_energy != 16'd0);

	// event registers
	logic [15:0]    lxe_q, csi_q;
	logic [13:0]    rad_q;
	logic [CNW-1:0] n_q, ic_q;
	logic [1:0]     fi_q;
	logic signed [15:0] feat_q [3];

	// table build sweep
	logic [TW-1:0] fill_cnt_q;
	logic [32:0]   u_q;
	logic [16:0]   fill_data;
	logic [65:0]   u_prod;

	assign fill_data = 17'((34'(u_q) + 34'd32768) >> 16);
	assign u_prod    = 66'(u_q) * 66'(EXP_RATIO) + (66'd1 << 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			u_q        <= 33'h1_0000_0000;
		end else if (fill_we) begin
			fill_cnt_q <= fill_cnt_q + 1'b1;
			u_q        <= 33'(u_prod >> 32);
		end
	end

	// center and weight stores
	logic [47:0] ctr_rd;
	logic [31:0] w_rd;

	rce_ram #(.W(48), .D(MAX_CENTERS), .AW(AW)) u_ctr_ram (
		.clk   (clk),
		.we    (load_hit),
		.waddr (AW'(item.slot)),
		.wdata ({item.center_c, item.center_b, item.center_a}),
		.raddr (ic_q[AW-1:0]),
		.rdata (ctr_rd)
	);

	rce_ram #(.W(32), .D(MAX_CENTERS), .AW(AW)) u_w_ram (
		.clk   (clk),
		.we    (load_hit),
		.waddr (AW'(item.slot)),
		.wdata (item.center_weight),
		.raddr (ic_q[AW-1:0]),
		.rdata (w_rd)
	);

	// feature numerators
	logic signed [16:0] da, db;
	logic signed [21:0] dc;
	logic signed [25:0] na, nb, nc, num_sel, num_abs;
	logic [8:0]  den_sel;
	logic [7:0]  half_sel;
	logic [RCP_W-1:0]  rcp_sel;
	logic [FNUM_W-1:0] fnum;
	logic [FPW-1:0]    fprod_q;

	assign da = $signed({1'b0, lxe_q}) - LXE_OFS;
	assign db = $signed({1'b0, csi_q}) - CSI_OFS;
	assign dc = $signed({1'b0, 21'(rad_q) * RAD_MUL}) - RAD_OFS;
	assign na = 26'(da) * A_MUL;
	assign nb = 26'(db) * B_MUL;
	assign nc = 26'(dc) * C_MUL;

	always_comb begin
		case (fi_q)
			2'd0:    begin num_sel = na; den_sel = A_DIV; rcp_sel = A_RCP; end
			2'd1:    begin num_sel = nb; den_sel = B_DIV; rcp_sel = B_RCP; end
			default: begin num_sel = nc; den_sel = C_DIV; rcp_sel = C_RCP; end
		endcase
		half_sel = den_sel[8:1];
		num_abs  = (num_sel < 0) ? -num_sel : num_sel;
	end

	// rounded magnitude over the divisor, as a product with its reciprocal
	assign fnum = FNUM_W'(unsigned'(num_abs)) + FNUM_W'(half_sel);

	always_ff @(posedge clk) begin
		if (state_q == ST_FSTART) begin
			fprod_q <= FPW'(fnum) * FPW'(rcp_sel);
		end
	end

	// serial divider for the weighted mean
	logic [SKW-1:0]       sum_k_q;
	logic signed [NW-1:0] sum_wk_q;
	logic [NW-1:0]        wk_abs;
	logic [NW-1:0]        div_dividend;
	logic [SKW-1:0]       div_divisor;
	logic [NB_W-1:0]      div_nbits;
	div_stat_t            div_stat;
	logic [QW-1:0]        div_quo;

	assign wk_abs = (sum_wk_q < 0) ? unsigned'(-sum_wk_q) : unsigned'(sum_wk_q);

	assign div_dividend = wk_abs + NW'(sum_k_q >> 1);
	assign div_divisor  = sum_k_q;
	assign div_nbits    = FINAL_QBITS;

	rce_div #(.DDW(NW), .RW(SKW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.stat     (div_stat),
		.quo      (div_quo)
	);

	// signed, saturated feature from the reciprocal product
	logic signed [18:0] fmag, fval;
	logic signed [15:0] fsat;

	assign fmag = $signed({1'b0, fprod_q[RCP_SHIFT +: FEAT_QBITS]});
	assign fval = (num_sel < 0) ? -fmag : fmag;
	assign fsat = (fval > 19'sd32767) ? 16'sh7fff
		: (fval < -19'sd32768) ? 16'sh8000 : fval[15:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	logic chain_fin_q;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		issue     = 1'b0;
		fill_we   = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				fill_we = 1'b1;
				if (fill_cnt_q == TW'(EXP_TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (is_eval && !rejected) begin
					state_d = ST_FSTART;
				end
			end
			ST_FSTART: begin
				state_d = ST_FWAIT;
			end
			ST_FWAIT: begin
				if (fi_q != 2'd2) begin
					state_d = ST_FSTART;
				end else if (n_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (ic_q == n_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (chain_fin_q) begin
					state_d = (sum_k_q == '0) ? ST_DONE : ST_QSTART;
				end
			end
			ST_QSTART: begin
				div_start = 1'b1;
				state_d   = ST_QWAIT;
			end
			ST_QWAIT: begin
				if (div_stat.done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q <= '0;
			ic_q <= '0;
			n_q  <= '0;
		end else begin
			if (is_eval) begin
				fi_q <= '0;
				ic_q <= '0;
				n_q  <= (11'(center_count_q) > 11'(MAX_CENTERS)) ? CNW'(MAX_CENTERS)
					: CNW'(center_count_q);
			end else begin
				if (state_q == ST_FWAIT) begin
					fi_q <= fi_q + 1'b1;
				end
				if (issue) begin
					ic_q <= ic_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_eval) begin
			lxe_q <= item.lxe_energy;
			csi_q <= item.csi_energy;
			rad_q <= item.radius;
		end
		if (state_q == ST_FWAIT) begin
			feat_q[fi_q] <= fsat;
		end
	end

	// read stage control
	ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= issue;
			ctl_s1.last <= issue && (ic_q == n_q - 1'b1);
		end
	end

	// distance chain
	ctl_t  ctl_c  [4];
	beat_t beat_c [4];

	assign ctl_c[0]         = ctl_s1;
	assign beat_c[0].psum   = '0;
	assign beat_c[0].weight = w_rd;
	assign beat_c[0].ctr    = ctr_rd;

	for (genvar gi = 0; gi < 3; gi++) begin : g_cell
		rce_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.feat     (feat_q[gi]),
			.ctl_in   (ctl_c[gi]),
			.beat_in  (beat_c[gi]),
			.ctl_out  (ctl_c[gi+1]),
			.beat_out (beat_c[gi+1])
		);
	end

	// kernel index, table read, weight product
	logic [49:0]  d2w;
	logic [16:0]  idx_s5;
	logic [31:0]  w_s5, w_s6;
	ctl_t         ctl_s5, ctl_s6, ctl_s7;
	logic         inr_s6;
	logic [16:0]  t_rd, k_s6;
	logic [16:0]  k_s7;
	logic signed [WKW-1:0] wk_s7;

	assign d2w  = 50'(beat_c[3].psum) * 50'(inv_width_q);
	assign k_s6 = inr_s6 ? t_rd : 17'd0;

	rce_ram #(.W(KW), .D(EXP_TABLE_DEPTH), .AW(TW)) u_exp_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_cnt_q),
		.wdata (fill_data),
		.raddr (idx_s5[TW-1:0]),
		.rdata (t_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			ctl_s7      <= '0;
			chain_fin_q <= 1'b0;
		end else begin
			ctl_s5      <= ctl_c[3];
			ctl_s6      <= ctl_s5;
			ctl_s7      <= ctl_s6;
			chain_fin_q <= ctl_s7.vld && ctl_s7.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s5 <= 17'((51'(d2w) + (51'd1 << 33)) >> 34);
		w_s5   <= beat_c[3].weight;
		inr_s6 <= idx_s5 < 17'(EXP_TABLE_DEPTH);
		w_s6   <= w_s5;
		k_s7   <= k_s6;
		wk_s7  <= WKW'($signed(w_s6)) * WKW'($signed({1'b0, k_s6}));
	end

	// sums over centers
	always_ff @(posedge clk) begin
		if (is_eval) begin
			sum_k_q  <= '0;
			sum_wk_q <= '0;
		end else if (ctl_s7.vld) begin
			sum_k_q  <= sum_k_q + SKW'(k_s7);
			sum_wk_q <= sum_wk_q + NW'(wk_s7);
		end
	end

	// quotient scaling
	logic signed [33:0] qs;
	logic signed [44:0] prod_q, e_val;
	logic [15:0] energy_val;

	assign qs = sum_wk_q[NW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign e_val = prod_q + E_OFFSET;
	assign energy_val = (e_val < 0) ? 16'd0
		: (e_val[44:32] != '0) ? 16'hffff : e_val[31:16];

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			prod_q <= 45'(qs) * E_SCALE;
		end
	end

	// result register
	logic done_q;
	out_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= is_load || (is_eval && rejected) || (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (is_load) begin
			res_q <= '{item_kind: KIND_LOAD, accepted: 1'b0, energy: 16'd0,
				no_response: 1'b0};
		end else if (is_eval && rejected) begin
			res_q <= '{item_kind: KIND_EVAL, accepted: 1'b0, energy: 16'd0,
				no_response: 1'b0};
		end else if (state_q == ST_DONE) begin
			res_q <= '{item_kind: KIND_EVAL, accepted: 1'b1,
				energy: (sum_k_q == '0) ? 16'd0 : energy_val,
				no_response: (sum_k_q == '0)};
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> done && (result.item_kind == KIND_LOAD))
		else $error("load beat not acknowledged next cycle");

	a_no_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.no_response) |-> (result.accepted && result.energy == 16'd0))
		else $error("no-response result carries energy");

	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (busy && !done))
		else $error("activity during table build");

	a_chain_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s7.vld |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("chain beat outside center sweep");
endmodule

// File: tb/tb_rbf_center_energy_regressor_unit.sv
// Self-checking testbench for the RBF center energy regressor unit.
`timescale 1ns / 100ps

module tb_rbf_center_energy_regressor_unit;
	import rce_pkg::*;

	localparam int NCTR = 64;
	localparam int NTAB = 1024;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_t                   item;
	logic                  done;
	out_t                  result;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_idx;
	logic [CFG_DATA_W-1:0] wr_data;

	rbf_center_energy_regressor_unit #(
		.MAX_CENTERS(NCTR),
		.EXP_TABLE_DEPTH(NTAB)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	// Predictor state
	longint unsigned kern_lut[NTAB];
	logic signed [15:0] ctr_a[NCTR], ctr_b[NCTR], ctr_c[NCTR];
	logic signed [31:0] ctr_w[NCTR];
	int unsigned mdl_inv_width, mdl_count, mdl_rho_min, mdl_theta_win;

	out_t energy_q[$];
	int   err_cnt = 0;
	int   n_load, n_reject, n_hit, n_empty;
	bit   gaps_on;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mismatch report
	task automatic report(input string what, input longint got, input longint want);
		err_cnt++;
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	function automatic longint round_div(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Kernel table: geometric decay of exp(-1/64) in Q0.32, rounded to Q1.16
	task automatic build_kernel_lut();
		longint unsigned u;
		u = 64'd1 << 32;
		for (int k = 0; k < NTAB; k++) begin
			kern_lut[k] = (u + 64'd32768) >> 16;
			u = (u * 64'd4228380000 + (64'd1 << 31)) >> 32;
		end
	endtask

	// Expected response to one accepted beat; loads update the stores
	function automatic out_t predict_energy(input in_t it);
		out_t   r;
		longint lxe, csi, rad, th, az, dth, sk, swk, q, e, d;
		longint fa, fb, fc, kv;
		longint unsigned d2, idx;
		int unsigned n;
		r = '0;
		r.item_kind = it.cmd;
		if (it.cmd == CMD_LOAD) begin
			ctr_a[it.slot] = it.center_a;
			ctr_b[it.slot] = it.center_b;
			ctr_c[it.slot] = it.center_c;
			ctr_w[it.slot] = it.center_weight;
			n_load++;
			return r;
		end
		lxe = it.lxe_energy;
		csi = it.csi_energy;
		rad = it.radius;
		th  = it.theta;
		az  = it.azimuth;
		dth = th - 12868;
		if (dth < 0)
			dth = -dth;
		if (az > 57344 || th > 32768 || rad < mdl_rho_min || dth > mdl_theta_win ||
				it.bgo_energy != 0) begin
			n_reject++;
			return r;
		end
		r.accepted = 1'b1;
		fa = clamp16(round_div((lxe - 6944) * 160, 93));
		fb = clamp16(round_div((csi - 4072) * 512, 305));
		fc = clamp16(round_div((100 * rad - 1022976) * 16, 285));
		n = (mdl_count > NCTR) ? NCTR : mdl_count;
		sk = 0;
		swk = 0;
		for (int j = 0; j < n; j++) begin
			d = fa - longint'(ctr_a[j]);
			d2 = d * d;
			d = fb - longint'(ctr_b[j]);
			d2 += d * d;
			d = fc - longint'(ctr_c[j]);
			d2 += d * d;
			idx = (d2 * mdl_inv_width + (64'd1 << 33)) >> 34;
			kv = (idx < NTAB) ? longint'(kern_lut[idx]) : 0;
			sk += kv;
			swk += longint'(ctr_w[j]) * kv;
		end
		if (sk == 0) begin
			r.no_response = 1'b1;
			n_empty++;
			return r;
		end
		n_hit++;
		q = round_div(swk, sk);
		e = 800 * q + longint'(12000) * 65536 + 32768;
		if (e < 0)
			e = 0;
		else begin
			e = e >>> 16;
			if (e > 65535)
				e = 65535;
		end
		r.energy = e[15:0];
		return r;
	endfunction

	// Result checker and watchdog
	int unsigned stall_cnt = 0;
	always @(posedge clk) begin
		out_t w;
		if (arst_n) begin
			if ((start && !busy) || done || wr_en)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= WATCHDOG_LIMIT) begin
				$display("watchdog expired at %0t", $realtime);
				$display("[FAIL] regression broken");
				$finish;
			end
			if (done) begin
				if (energy_q.size() == 0)
					report("unexpected result beat", result, 0);
				else begin
					w = energy_q.pop_front();
					if (result.item_kind != w.item_kind)
						report("item_kind", result.item_kind, w.item_kind);
					if (result.accepted != w.accepted)
						report("accepted", result.accepted, w.accepted);
					if (result.energy != w.energy)
						report("energy", result.energy, w.energy);
					if (result.no_response != w.no_response)
						report("no_response", result.no_response, w.no_response);
				end
			end
		end
	end

	// Send one beat; returns after the edge that takes it, start left high
	task automatic send_beat(input in_t it);
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		energy_q = {energy_q, predict_energy(it)};
	endtask

	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until all results are back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (energy_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input int unsigned inv, input int unsigned cnt,
			input int unsigned rho, input int unsigned win);
		int unsigned v[4];
		v = '{inv, cnt, rho, win};
		for (int i = 0; i < 4; i++) begin
			wr_en   <= 1'b1;
			wr_idx  <= CFG_IDX_W'(i);
			wr_data <= CFG_DATA_W'(v[i]);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
		mdl_inv_width = inv & 16'hFFFF;
		mdl_count     = cnt & 7'h7F;
		mdl_rho_min   = rho & 14'h3FFF;
		mdl_theta_win = win & 13'h1FFF;
	endtask

	function automatic in_t noise_beat();
		in_t it;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_t)-1:0];
		return it;
	endfunction

	// Center load; weights mostly modest, sometimes full range
	function automatic in_t load_beat(input int unsigned slot);
		in_t it;
		it = noise_beat();
		it.cmd = CMD_LOAD;
		it.slot = slot[5:0];
		it.center_a = 16'($urandom_range(0, 32767)) - 16'sd16384;
		it.center_b = 16'($urandom_range(0, 32767)) - 16'sd16384;
		it.center_c = 16'($urandom_range(0, 32767)) - 16'sd16384;
		if ($urandom_range(0, 4) != 0)
			it.center_weight = 32'($urandom_range(0, 400 << 16)) - 32'sd13107200;
		return it;
	endfunction

	// Event that passes the current cuts, features near the center cloud
	function automatic in_t good_event();
		in_t it;
		it = noise_beat();
		it.cmd = CMD_EVAL;
		it.bgo_energy = '0;
		it.azimuth = 16'($urandom_range(0, 57344));
		it.theta = 16'($urandom_range(12868 - mdl_theta_win, 12868 + mdl_theta_win));
		it.radius = 14'($urandom_range(mdl_rho_min, 16383));
		if ($urandom_range(0, 4) != 0) begin
			it.lxe_energy = 16'($urandom_range(0, 16000));
			it.csi_energy = 16'($urandom_range(0, 13000));
		end
		return it;
	endfunction

	task automatic run_mix(input int cnt);
		int unsigned p;
		for (int i = 0; i < cnt; i++) begin
			p = $urandom_range(0, 99);
			if (p < 10)
				send_beat(load_beat($urandom_range(0, NCTR - 1)));
			else if (p < 25)
				send_beat(noise_beat());
			else
				send_beat(good_event());
			maybe_gap();
		end
	endtask

	task automatic test_load_centers();
		in_t it;
		for (int s = 0; s < NCTR; s++) begin
			it = load_beat(s);
			// extreme corners on the first slots
			if (s == 0) begin
				it.center_a = 16'sh7FFF;
				it.center_b = 16'sh8000;
				it.center_weight = 32'sh7FFFFFFF;
			end else if (s == 1) begin
				it.center_a = '0;
				it.center_b = '0;
				it.center_c = 16'sh8000;
				it.center_weight = 32'sh80000000;
			end
			send_beat(it);
			maybe_gap();
		end
	endtask

	// Cut boundaries and feature extremes at reset settings
	task automatic test_cuts();
		in_t base, it;
		base = '0;
		base.cmd = CMD_EVAL;
		base.lxe_energy = 16'd6944;
		base.csi_energy = 16'd4072;
		base.radius = 14'd10230;
		base.theta = 16'd12868;
		send_beat(base);
		it = base; it.azimuth = 16'd57344;  send_beat(it);
		it = base; it.azimuth = 16'd57345;  send_beat(it);
		it = base; it.azimuth = 16'hFFFF;   send_beat(it);
		it = base; it.theta = 16'd32769;    send_beat(it);
		it = base; it.theta = 16'hFFFF;     send_beat(it);
		it = base; it.theta = 16'd17537;    send_beat(it);
		it = base; it.theta = 16'd17538;    send_beat(it);
		it = base; it.theta = 16'd8198;     send_beat(it);
		it = base; it.radius = 14'd9471;    send_beat(it);
		it = base; it.radius = 14'd9472;    send_beat(it);
		it = base; it.radius = 14'h3FFF;    send_beat(it);
		it = base; it.bgo_energy = 16'd1;   send_beat(it);
		it = base; it.bgo_energy = 16'hFFFF; send_beat(it);
		it = base; it.lxe_energy = 16'd0;   send_beat(it);
		it = base; it.lxe_energy = 16'hFFFF; it.csi_energy = 16'hFFFF; send_beat(it);
		it = base; it.csi_energy = 16'd0;   send_beat(it);
		drain();
	endtask

	// Register sweeps: widest and narrowest kernels, zero and oversized counts
	task automatic test_settings();
		set_regs(0, 64, 0, 8191);       run_mix(180); drain();
		set_regs(65535, 64, 16383, 0);  run_mix(120); drain();
		set_regs(6554, 1, 9472, 4669);  run_mix(200); drain();
		set_regs(20000, 0, 0, 8191);    run_mix(100); drain();
		set_regs(3000, 127, 5000, 6000); run_mix(200); drain();
		set_regs($urandom_range(0, 65535), $urandom_range(1, 64),
			$urandom_range(0, 16383), $urandom_range(0, 8191));
		run_mix(250); drain();
		set_regs(1500, 32, 0, 8191);    run_mix(250); drain();
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		set_regs(6554, 64, 9472, 4669);
		run_mix(300);
		drain();
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = '0;
		gaps_on = 1'b1;
		build_kernel_lut();
		mdl_inv_width = 6554;
		mdl_count     = 64;
		mdl_rho_min   = 9472;
		mdl_theta_win = 4669;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_centers();
		test_cuts();
		test_settings();
		test_back_to_back();

		repeat (20) @(posedge clk);
		$display("covered %0d loads, %0d rejected events, %0d energies, %0d empty sums",
			n_load, n_reject, n_hit, n_empty);
		$display("left %0d pending results, %0d mismatches", energy_q.size(), err_cnt);
		if (err_cnt == 0 && energy_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
